@@ hdl/trigram_bloom_signature_macros.svh @@
// Assertion helpers for the block's top module.
// Every property is sampled on the rising edge of clock and is off while reset is high.
`ifndef TRIGRAM_BLOOM_SIGNATURE_MACROS_SVH
`define TRIGRAM_BLOOM_SIGNATURE_MACROS_SVH

// The consequent is checked in the same cycle as the antecedent.
`define TBS_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) \
      else $error("tbs: same-cycle check failed");

// The consequent is checked in the cycle after the antecedent.
`define TBS_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error("tbs: next-cycle check failed");

`endif

@@ hdl/tbs_pkg.sv @@
package tbs_pkg;

   localparam int SLOT_W = 3;
   localparam int BYTE_W = 8;
   localparam int MAP_W = 256;
   localparam int PROBES = 4;
   localparam int KEY_W = 3 * BYTE_W;
   // The low byte of the final hash needs product bits up to bit 40 (bit 7 plus the 33 shift).
   localparam int MIX_W = 41;
   localparam int MUL_HI_W = MIX_W - 32;

   // Request kinds.
   localparam logic FUNC_BUILD = 1'b0;
   localparam logic FUNC_PROBE = 1'b1;

   // Hash multiplier split into its low 32 bits and the bits 40..32 above them.
   localparam logic [31:0] HASH_MUL_LO = 32'hed55_8ccd;
   localparam logic [MUL_HI_W-1:0] HASH_MUL_HI = 9'h1d7;

   // Low byte of k times the probe step, for k = 0..3.
   localparam logic [BYTE_W-1:0] PROBE_OFS [PROBES] = '{8'h00, 8'h15, 8'h2a, 8'h3f};

   // One request as it travels down the pipeline.
   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] data_byte;
      logic              first;
      logic              last;
      logic              trigram;
   } tbs_item_type;

endpackage

@@ hdl/trigram_bloom_signature.sv @@
// Trigram Bloom signature.
// Each slot holds a 256-bit byte-presence map and a 256-bit Bloom filter of
// hashed byte trigrams (four probe bits per trigram), plus a filter valid flag.
// Requests: start with req_func, req_slot, req_data_byte, req_first, req_last.
// A request is taken at every rising edge with start high; busy stays low, so
// one byte per cycle is sustained.
// Build requests (func 0) set presence and Bloom bits; a first byte clears the
// slot. Probe requests (func 1) check needle bytes against the slot.
// A request with req_last high produces one response, on rsp_* with rsp_strobe
// high for one cycle. The pipeline is input register, hash multiply register,
// then store update and response register.
// The response receiver cannot stall, so there is no backpressure path.
// Reset empties all slots, clears valid flags, byte history and probe status,
// and flushes requests still in the pipeline.
module trigram_bloom_signature
   import tbs_pkg::*;
#(
   parameter int SLOTS = 8
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_first,
   input  logic              req_last,
   output logic              rsp_strobe,
   output logic              rsp_kind,
   output logic [SLOT_W-1:0] rsp_slot_out,
   output logic              rsp_may_contain,
   output logic              rsp_bloom_valid
);

   `include "trigram_bloom_signature_macros.svh"

   // Only slots reachable by the slot field get storage.
   localparam int DEPTH = (SLOTS < (2 ** SLOT_W)) ? SLOTS : (2 ** SLOT_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                 accept;
   logic [2*BYTE_W-1:0]  hist_ff, hist_in, hist_eff;
   logic [1:0]           seen_ff, seen_in, seen_eff;

   logic                 s1_valid_ff;
   tbs_item_type         s1_item_ff, s1_item_in;
   logic [KEY_W-1:0]     s1_key_ff;

   logic                 s2_valid;
   tbs_item_type         s2_item;
   logic [BYTE_W-1:0]    s2_hash;

   logic [MAP_W-1:0]     pres_ff [DEPTH];
   logic [MAP_W-1:0]     bloom_ff [DEPTH];
   logic [DEPTH-1:0]     row_vld_ff;
   logic [DEPTH-1:0]     bv_ff;
   logic                 pf_ff, pf_in;

   logic                 slot_ok;
   logic [IDX_W-1:0]     idx;
   logic [BYTE_W-1:0]    probe_pos [PROBES];
   logic [MAP_W-1:0]     probe_mask;
   logic [MAP_W-1:0]     pres_cur, bloom_cur, pres_new, bloom_new;
   logic                 bv_cur, bv_new;
   logic                 probe_hit, probe_fail;
   logic                 is_build, wr_en;

   logic                 strobe_ff;
   logic                 kind_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 may_ff;
   logic                 bvout_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Shared byte history: a first byte restarts it, the count saturates at three.
   always_comb begin
      hist_eff = req_first ? '0 : hist_ff;
      seen_eff = req_first ? '0 : seen_ff;
      hist_in  = hist_ff;
      seen_in  = seen_ff;
      if (accept) begin
         hist_in = {hist_eff[BYTE_W-1:0], req_data_byte};
         seen_in = (seen_eff == 2'd3) ? 2'd3 : seen_eff + 2'd1;
      end
      s1_item_in.func      = req_func;
      s1_item_in.slot      = req_slot;
      s1_item_in.data_byte = req_data_byte;
      s1_item_in.first     = req_first;
      s1_item_in.last      = req_last;
      s1_item_in.trigram   = (seen_eff >= 2'd2);
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff     <= '0;
         seen_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         hist_ff     <= hist_in;
         seen_ff     <= seen_in;
         s1_valid_ff <= accept;
      end
      s1_item_ff <= s1_item_in;
      s1_key_ff  <= {hist_eff, req_data_byte};
   end

   // Trigram hash stage.
   tbs_hash u_hash (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_item   (s1_item_ff),
      .in_key    (s1_key_ff),
      .out_valid (s2_valid),
      .out_item  (s2_item),
      .out_hash  (s2_hash)
   );

   // Slot lookup, probe bit positions and the read-modify-write of the slot.
   always_comb begin
      slot_ok  = (int'(s2_item.slot) < SLOTS);
      idx      = slot_ok ? s2_item.slot[IDX_W-1:0] : '0;
      is_build = (s2_item.func == FUNC_BUILD);

      probe_mask = '0;
      for (int k = 0; k < PROBES; k++) begin
         probe_pos[k] = s2_hash + PROBE_OFS[k];
         probe_mask   = probe_mask | (MAP_W'(1) << probe_pos[k]);
      end

      // A row never written reads as empty.
      pres_cur  = row_vld_ff[idx] ? pres_ff[idx] : '0;
      bloom_cur = row_vld_ff[idx] ? bloom_ff[idx] : '0;
      bv_cur    = bv_ff[idx];

      // Build: a first byte starts from an empty slot.
      pres_new  = (s2_item.first ? '0 : pres_cur) | (MAP_W'(1) << s2_item.data_byte);
      bloom_new = (s2_item.first ? '0 : bloom_cur) | (s2_item.trigram ? probe_mask : '0);
      bv_new    = (s2_item.first ? 1'b0 : bv_cur) | s2_item.trigram;
      wr_en     = s2_valid && is_build && slot_ok;

      // Probe: every byte must be present, every trigram must hit when the filter is valid.
      probe_hit  = ((bloom_cur & probe_mask) == probe_mask);
      probe_fail = !slot_ok || !pres_cur[s2_item.data_byte]
                   || (s2_item.trigram && bv_cur && !probe_hit);
      pf_in = ((s2_item.first ? 1'b0 : pf_ff) | probe_fail);
   end

   // Slot storage: payload rows, with per-row valid bits and filter flags under reset.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         pres_ff[idx]  <= pres_new;
         bloom_ff[idx] <= bloom_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         bv_ff      <= '0;
         pf_ff      <= 1'b0;
      end else begin
         if (wr_en) begin
            row_vld_ff[idx] <= 1'b1;
            bv_ff[idx]      <= bv_new;
         end
         if (s2_valid && !is_build) begin
            pf_ff <= pf_in;
         end
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= s2_valid && s2_item.last;
      end
      kind_ff  <= s2_item.func;
      slot_ff  <= s2_item.slot;
      may_ff   <= !is_build && !pf_in;
      bvout_ff <= slot_ok && (is_build ? bv_new : bv_cur);
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_slot_out    = slot_ff;
   assign rsp_may_contain = may_ff;
   assign rsp_bloom_valid = bvout_ff;

   // A last byte always yields a response.
   `TBS_ASSERT_IMP(a_last_responds, accept && req_last, ##3 rsp_strobe)
   // Build responses never claim a match.
   `TBS_ASSERT_IMP(a_build_no_match, rsp_strobe && (rsp_kind == FUNC_BUILD), !rsp_may_contain)
   // A slot without storage never reports a valid filter or a possible match.
   `TBS_ASSERT_IMP(a_bad_slot_invalid, rsp_strobe && (int'(rsp_slot_out) >= SLOTS),
                   !rsp_bloom_valid && !rsp_may_contain)
   // A build trigram on a stored slot leaves the filter flag set.
   `TBS_ASSERT_NXT(a_trigram_sets_valid, wr_en && s2_item.trigram, bv_ff[$past(idx)])

endmodule

@@ hdl/tbs_hash.sv @@
module tbs_hash
   import tbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  tbs_item_type       in_item,
   input  logic [KEY_W-1:0]   in_key,
   output logic               out_valid,
   output tbs_item_type       out_item,
   output logic [BYTE_W-1:0]  out_hash
);

   logic                valid_ff;
   tbs_item_type        item_ff;
   logic [MIX_W-1:0]    mix_ff;
   logic [MIX_W-1:0]    mix_in;
   logic [55:0]         lo_prod;
   logic [17:0]         hi_prod;

   // Trigram times the hash multiplier, kept modulo 2^41.
   // The high part only contributes its low nine bits above bit 32.
   always_comb begin
      lo_prod = 56'(in_key) * 56'(HASH_MUL_LO);
      hi_prod = 18'(in_key[MUL_HI_W-1:0]) * 18'(HASH_MUL_HI);
      mix_in  = lo_prod[MIX_W-1:0] + {hi_prod[MUL_HI_W-1:0], 32'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      item_ff <= in_item;
      mix_ff  <= mix_in;
   end

   // Final fold x ^= x >> 33, restricted to the byte that selects probe bits.
   assign out_valid = valid_ff;
   assign out_item  = item_ff;
   assign out_hash  = mix_ff[BYTE_W-1:0] ^ mix_ff[33 +: BYTE_W];

endmodule

@@ tb/sv/tb.sv @@
module tb;
   import tbs_pkg::*;

   localparam int SLOTS = 8;
   localparam int RANDOM_TARGET = 1975;
   localparam int CYCLE_LIMIT = 500000;
   localparam logic [63:0] HASH_MUL = 64'hff51_afd7_ed55_8ccd;
   localparam logic [63:0] PROBE_STEP = 64'h9e37_79b9_7f4a_7c15;

   typedef struct packed {
      logic              func;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] data;
      logic              first;
      logic              last;
   } byte_req_t;

   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic              may_contain;
      logic              bloom_valid;
   } answer_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic              req_func = 1'b0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic              req_first = 1'b0;
   logic              req_last = 1'b0;
   logic              rsp_strobe;
   logic              rsp_kind;
   logic [SLOT_W-1:0] rsp_slot_out;
   logic              rsp_may_contain;
   logic              rsp_bloom_valid;

   // Requests waiting to be driven and answers waiting to come back.
   byte_req_t byte_queue[$];
   answer_t   answers_due[$];
   byte_req_t next_req;
   int        idle_left = 0;
   int        burst_left = 0;
   int        n_pushed = 0;
   int        n_accepted = 0;
   int        n_build_ans = 0;
   int        n_probe_ans = 0;
   int        n_hits = 0;
   int        errors = 0;
   int        cycles = 0;

   // Shadow copy of the signature stores and the shared run state.
   logic [MAP_W-1:0]  presence_map [SLOTS];
   logic [MAP_W-1:0]  bloom_map [SLOTS];
   logic              filter_ok [SLOTS];
   logic [15:0]       recent_bytes;
   logic [1:0]        run_count;
   logic              needle_missed;

   // Last span built into each slot, used to form needles that should hit.
   logic [BYTE_W-1:0] span_bytes [SLOTS][16];
   int                span_len [SLOTS];
   logic [BYTE_W-1:0] seq_bytes [16];

   trigram_bloom_signature #(.SLOTS(SLOTS)) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_func        (req_func),
      .req_slot        (req_slot),
      .req_data_byte   (req_data_byte),
      .req_first       (req_first),
      .req_last        (req_last),
      .rsp_strobe      (rsp_strobe),
      .rsp_kind        (rsp_kind),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_may_contain (rsp_may_contain),
      .rsp_bloom_valid (rsp_bloom_valid)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mix a byte trigram into a 64-bit hash.
   function automatic logic [63:0] trigram_hash(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      logic [63:0] x;
      x = {40'd0, a, b, c};
      x = x ^ (x >> 33);
      x = x * HASH_MUL;
      x = x ^ (x >> 33);
      return x;
   endfunction

   // Bloom bit selected by probe k of a hash.
   function automatic logic [7:0] probe_index(logic [63:0] h, int k);
      logic [63:0] s;
      s = h + 64'(k) * PROBE_STEP;
      return s[7:0];
   endfunction

   task automatic clear_signature();
      for (int i = 0; i < SLOTS; i++) begin
         presence_map[i] = '0;
         bloom_map[i] = '0;
         filter_ok[i] = 1'b0;
      end
      recent_bytes = '0;
      run_count = '0;
      needle_missed = 1'b0;
   endtask

   // Apply one accepted request to the shadow stores and queue an answer for a last byte.
   task automatic predict_signature(input byte_req_t r);
      logic [63:0] h;
      logic        fits;
      logic        has_trigram;
      answer_t     a;
      fits = int'(r.slot) < SLOTS;
      if (r.first) begin
         recent_bytes = '0;
         run_count = '0;
         if (r.func == FUNC_BUILD && fits) begin
            presence_map[r.slot] = '0;
            bloom_map[r.slot] = '0;
            filter_ok[r.slot] = 1'b0;
         end
         if (r.func == FUNC_PROBE) needle_missed = 1'b0;
      end
      has_trigram = run_count >= 2;
      h = trigram_hash(recent_bytes[15:8], recent_bytes[7:0], r.data);
      if (r.func == FUNC_BUILD) begin
         if (fits) begin
            presence_map[r.slot][r.data] = 1'b1;
            if (has_trigram) begin
               for (int k = 0; k < PROBES; k++) bloom_map[r.slot][probe_index(h, k)] = 1'b1;
            end
         end
      end else begin
         if (!fits || !presence_map[r.slot][r.data]) begin
            needle_missed = 1'b1;
         end else if (has_trigram && filter_ok[r.slot]) begin
            for (int k = 0; k < PROBES; k++) begin
               if (!bloom_map[r.slot][probe_index(h, k)]) needle_missed = 1'b1;
            end
         end
      end
      if (run_count < 3) run_count++;
      if (r.func == FUNC_BUILD && fits && run_count == 3) filter_ok[r.slot] = 1'b1;
      recent_bytes = {recent_bytes[7:0], r.data};
      if (r.last) begin
         a.kind = r.func;
         a.slot = r.slot;
         a.may_contain = (r.func == FUNC_PROBE) && !needle_missed;
         a.bloom_valid = fits ? filter_ok[r.slot] : 1'b0;
         answers_due.push_back(a);
         if (r.func == FUNC_BUILD) n_build_ans++;
         else n_probe_ans++;
         if (a.may_contain) n_hits++;
      end
   endtask

   task automatic push_req(input logic func, input logic [2:0] slot, input logic [7:0] data,
                           input logic first, input logic last);
      byte_req_t r;
      r.func = func;
      r.slot = slot;
      r.data = data;
      r.first = first;
      r.last = last;
      byte_queue.push_back(r);
      n_pushed++;
   endtask

   // Send seq_bytes as one span or needle; a build span is remembered per slot.
   task automatic send_seq(input logic func, input logic [2:0] slot, input int len);
      for (int i = 0; i < len; i++) push_req(func, slot, seq_bytes[i], i == 0, i == len - 1);
      if (func == FUNC_BUILD) begin
         for (int i = 0; i < len; i++) span_bytes[slot][i] = seq_bytes[i];
         span_len[slot] = len;
      end
   endtask

   // Bytes are given most significant first so the hex reads in stream order.
   task automatic send_packed(input logic func, input logic [2:0] slot, input int len,
                              input logic [63:0] bytes);
      for (int i = 0; i < len; i++) seq_bytes[i] = bytes[8 * (len - 1 - i) +: 8];
      send_seq(func, slot, len);
   endtask

   // Gap before the next request: mostly none or short, a few long, with idle-free bursts.
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) burst_left = $urandom_range(40, 150);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   // Request driver: predicts on acceptance, then loads the next request or idles.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left <= 0;
      end else begin
         if (start && !busy) begin
            predict_signature({req_func, req_slot, req_data_byte, req_first, req_last});
            n_accepted++;
         end
         if (start && busy) begin
            // Hold the request until the block takes it.
         end else if (idle_left > 0) begin
            start <= 1'b0;
            idle_left <= idle_left - 1;
         end else if (byte_queue.size() > 0) begin
            next_req = byte_queue.pop_front();
            req_func <= next_req.func;
            req_slot <= next_req.slot;
            req_data_byte <= next_req.data;
            req_first <= next_req.first;
            req_last <= next_req.last;
            start <= 1'b1;
            idle_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endtask

   // Response monitor: every strobe must match the oldest outstanding answer.
   always @(posedge clock) begin
      answer_t a;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            $error("response with no request outstanding: slot %0d", rsp_slot_out);
            errors++;
         end else begin
            a = answers_due.pop_front();
            check_field("kind", 8'(a.kind), 8'(rsp_kind));
            check_field("slot_out", 8'(a.slot), 8'(rsp_slot_out));
            check_field("may_contain", 8'(a.may_contain), 8'(rsp_may_contain));
            check_field("bloom_valid", 8'(a.bloom_valid), 8'(rsp_bloom_valid));
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int          r;
      int          len;
      int          nal;
      int          st;
      logic [2:0]  sl;
      logic [7:0]  alpha [8];
      clear_signature();
      for (int i = 0; i < SLOTS; i++) span_len[i] = 0;

      // Probe of a slot that was never built: nothing is present.
      send_packed(FUNC_PROBE, 3'd2, 1, 64'h41);
      // Extreme bytes into slot 0, then a matching, a scrambled and short needles.
      send_packed(FUNC_BUILD, 3'd0, 4, 64'h00ff_807f);
      send_packed(FUNC_PROBE, 3'd0, 3, 64'hff_807f);
      send_packed(FUNC_PROBE, 3'd0, 3, 64'h00_80ff);
      send_packed(FUNC_PROBE, 3'd0, 1, 64'h00);
      send_packed(FUNC_PROBE, 3'd0, 2, 64'h7f00);
      send_packed(FUNC_PROBE, 3'd0, 1, 64'h01);
      // Two-byte span leaves the filter invalid, so only presence counts.
      send_packed(FUNC_BUILD, 3'd7, 2, 64'h55aa);
      send_packed(FUNC_PROBE, 3'd7, 4, 64'haa55_aa55);
      // One-byte span, then bytes without a first marker continue that run.
      send_packed(FUNC_BUILD, 3'd3, 1, 64'h33);
      push_req(FUNC_BUILD, 3'd3, 8'h44, 1'b0, 1'b0);
      push_req(FUNC_BUILD, 3'd3, 8'h45, 1'b0, 1'b1);
      // Rebuilding slot 0 clears what was there.
      send_packed(FUNC_BUILD, 3'd0, 3, 64'h12_3456);
      send_packed(FUNC_PROBE, 3'd0, 1, 64'hff);

      // Random traffic: mostly well-formed spans and needles, some stray bytes.
      while (n_pushed < RANDOM_TARGET) begin
         r = $urandom_range(0, 99);
         sl = 3'($urandom_range(0, SLOTS - 1));
         if (r < 45) begin
            len = ($urandom_range(0, 9) < 2) ? $urandom_range(1, 2) : $urandom_range(3, 10);
            nal = $urandom_range(1, 8);
            for (int i = 0; i < nal; i++) alpha[i] = 8'($urandom_range(0, 255));
            for (int i = 0; i < len; i++) seq_bytes[i] = alpha[$urandom_range(0, nal - 1)];
            send_seq(FUNC_BUILD, sl, len);
         end else if (r < 85) begin
            if (span_len[sl] > 0 && $urandom_range(0, 2) != 0) begin
               st = $urandom_range(0, span_len[sl] - 1);
               len = $urandom_range(1, span_len[sl] - st);
               for (int i = 0; i < len; i++) seq_bytes[i] = span_bytes[sl][st + i];
            end else begin
               len = $urandom_range(1, 6);
               for (int i = 0; i < len; i++) begin
                  if (span_len[sl] > 0 && $urandom_range(0, 1) == 1)
                     seq_bytes[i] = span_bytes[sl][$urandom_range(0, span_len[sl] - 1)];
                  else
                     seq_bytes[i] = 8'($urandom_range(0, 255));
               end
            end
            send_seq(FUNC_PROBE, sl, len);
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               push_req(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                        8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)));
            end
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Drain: all requests taken, all answers back, then the bus idles before the summary.
      while (byte_queue.size() != 0 || start) @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests; got %0d build completions and %0d probe answers.",
               n_accepted, n_build_ans, n_probe_ans);
      $display("%0d probes reported a possible match.", n_hits);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/tbs_pkg.sv
hdl/tbs_hash.sv
hdl/trigram_bloom_signature.sv
tb/sv/tb.sv
